/* sv/gcd3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd3_pkg: shared types and constants for gcd_of_three
// Default operand width and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gcd3_pkg;

    localparam int VALUE_BITS_DEFAULT = 31;

    typedef struct packed {
        logic load_in;    // capture a request: x = first, y = second, c = third
        logic load_c;     // x = gcd of pass one, y = c
        logic step;       // one binary gcd step
        logic store_out;  // write gcd to the output register
    } gcd3_cmd_t;

    typedef struct packed {
        logic done;       // x or y is zero: gcd of the pass is ready
    } gcd3_stat_t;

endpackage

/* sv/gcd3_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd3_datapath: binary gcd datapath
// Operand registers, common power-of-two count, one subtract-and-shift
// unit and the output register.
// ----------------------------------------------------------------------------
module gcd3_datapath
    import gcd3_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  gcd3_cmd_t             cmd,
    input  logic [VALUE_BITS-1:0] first_value,
    input  logic [VALUE_BITS-1:0] second_value,
    input  logic [VALUE_BITS-1:0] third_value,
    output gcd3_stat_t            stat,
    output logic [VALUE_BITS-1:0] divisor
);

    localparam int SHIFT_BITS = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic [VALUE_BITS-1:0] y_reg, y_next;
    logic [VALUE_BITS-1:0] c_reg, c_next;
    logic [SHIFT_BITS-1:0] k_reg, k_next;
    logic [VALUE_BITS-1:0] divisor_reg, divisor_next;
    logic [VALUE_BITS:0]   diff_xy;
    logic [VALUE_BITS:0]   diff_yx;
    logic [VALUE_BITS-1:0] gcd_val;

    assign diff_xy = {1'b0, x_reg} - {1'b0, y_reg};
    assign diff_yx = {1'b0, y_reg} - {1'b0, x_reg};
    // one operand is zero when done, so x | y is the other operand
    assign gcd_val = VALUE_BITS'((x_reg | y_reg) << k_reg);

    assign stat.done = (x_reg == '0) || (y_reg == '0);
    assign divisor   = divisor_reg;

    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        divisor_next = divisor_reg;
        if (cmd.load_in)
        begin
            x_next = first_value;
            y_next = second_value;
            c_next = third_value;
            k_next = '0;
        end
        else if (cmd.load_c)
        begin
            x_next = gcd_val;
            y_next = c_reg;
            k_next = '0;
        end
        else if (cmd.step)
        begin
            priority if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + SHIFT_BITS'(1);
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (!diff_xy[VALUE_BITS])
            begin
                x_next = {1'b0, diff_xy[VALUE_BITS-1:1]};
            end
            else
            begin
                y_next = {1'b0, diff_yx[VALUE_BITS-1:1]};
            end
        end
        if (cmd.store_out)
        begin
            divisor_next = gcd_val;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        c_reg       <= c_next;
        k_reg       <= k_next;
        divisor_reg <= divisor_next;
    end

endmodule

/* sv/gcd3_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd3_controller: sequencer for gcd_of_three
// Runs two gcd passes per request and owns the input and output handshake.
// ----------------------------------------------------------------------------
module gcd3_controller
    import gcd3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  gcd3_stat_t stat,
    output gcd3_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (stat.done)
                begin
                    cmd.load_c = 1'b1;
                    state_next = ST_SECOND;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_SECOND:
            begin
                if (stat.done)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        cmd.store_out = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.store_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.load_c, cmd.step, cmd.store_out}))
        else $error("more than one datapath command");
    a_no_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !stat.done)
        else $error("step issued on a finished pass");
    a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_out |-> stat.done && (state_reg == ST_SECOND))
        else $error("result stored before second pass finished");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_out |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");
`endif

endmodule

/* sv/gcd_of_three.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_of_three: greatest common divisor of three operands
// Computes gcd(gcd(first, second), third) with an iterative binary gcd.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields, lowest bit first
//  s_*     | in  | first_value, second_value, third_value
//  m_*     | out | divisor
//
//  A request is worked through by the single subtract-and-shift unit:
//  the accept, then two gcd passes, each stepping until x or y is zero
//  and then finishing.
//  One request is in work at a time; the output register holds a result
//  while the next request is taken. A result still waiting at the output
//  holds the end of the second pass and keeps the input closed.
//  Reset clears the controller and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module gcd_of_three
    import gcd3_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // first_value, second_value, third_value, zero pad
    input  logic [((3*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // divisor, zero pad
    output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    gcd3_cmd_t             cmd;
    gcd3_stat_t            stat;
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] second_value;
    logic [VALUE_BITS-1:0] third_value;
    logic [VALUE_BITS-1:0] divisor;

    assign first_value  = s_tdata[VALUE_BITS-1:0];
    assign second_value = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign third_value  = s_tdata[3*VALUE_BITS-1:2*VALUE_BITS];
    assign m_tdata      = OUT_DATA_BITS'(divisor);

    gcd3_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gcd3_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .first_value  (first_value),
        .second_value (second_value),
        .third_value  (third_value),
        .stat         (stat),
        .divisor      (divisor)
    );

endmodule
